FILE: sv/cfdc_pkg.sv
// ============================================================================
// cfdc_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// frame decoder and checker.
// ============================================================================
`default_nettype none

package cfdc_pkg;

    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int CRC_W    = 16;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam int HDR_BYTES = 10;
    localparam int CRC_BYTES = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Header byte positions
    localparam logic [COUNT_W-1:0] POS_SYNC0   = 9'd0;
    localparam logic [COUNT_W-1:0] POS_SYNC1   = 9'd1;
    localparam logic [COUNT_W-1:0] POS_VERSION = 9'd2;
    localparam logic [COUNT_W-1:0] POS_SOURCE  = 9'd3;
    localparam logic [COUNT_W-1:0] POS_DEST    = 9'd4;
    localparam logic [COUNT_W-1:0] POS_TYPE    = 9'd5;
    localparam logic [COUNT_W-1:0] POS_FLAGS   = 9'd6;
    localparam logic [COUNT_W-1:0] POS_SEQ_HI  = 9'd7;
    localparam logic [COUNT_W-1:0] POS_SEQ_LO  = 9'd8;
    localparam logic [COUNT_W-1:0] POS_LENGTH  = 9'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] RST_VERSION     = 8'h01;
    localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD = 8'hFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_SYNC     = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_TOO_LARGE    = 3'd4,
        ST_LEN_MISMATCH = 3'd5,
        ST_CRC_MISMATCH = 3'd6
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_item_kind;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cfdc_in_if.sv
// ============================================================================
// cfdc_in_if
// Byte stream channel into the frame decoder: one frame byte and its
// end-of-frame flag per transfer.
// ============================================================================
`default_nettype none

interface cfdc_in_if;
    import cfdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: sv/cfdc_out_if.sv
// ============================================================================
// cfdc_out_if
// Result channel of the frame decoder: a payload byte or an end-of-frame
// status with the captured header fields.
// ============================================================================
`default_nettype none

interface cfdc_out_if;
    import cfdc_pkg::*;

    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   payload_index;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   source_node;
    logic [BYTE_W-1:0]   dest_node;
    logic [BYTE_W-1:0]   message_type;
    logic [BYTE_W-1:0]   flag_bits;
    logic [SEQ_W-1:0]    sequence_number;
    logic [BYTE_W-1:0]   payload_count;

    modport source (output valid, output item_kind, output payload_byte,
                    output payload_index, output status, output source_node,
                    output dest_node, output message_type, output flag_bits,
                    output sequence_number, output payload_count, input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input payload_index, input status, input source_node,
                    input dest_node, input message_type, input flag_bits,
                    input sequence_number, input payload_count, output ready);
endinterface

`default_nettype wire

FILE: sv/crc_frame_decoder_checker_top.sv
// ============================================================================
// crc_frame_decoder_checker_top
// Sync-header frame deframer with CRC-16/CCITT-FALSE check: forwards payload
// bytes and reports one status per frame on its last byte.
// ============================================================================
//
//  Channel   Direction  Carries
//  --------  ---------  ------------------------------------------------------
//  in_ch     sink       rx_byte, end_of_frame (one frame byte per transfer)
//  out_ch    source     payload byte + index, or status + header fields
//  i_cfg_*   input      write enable, 2-bit register index, 8-bit data
//
//  Throughput is one byte per cycle while out_ch does not stall; a result
//  goes valid once its byte has passed the input register and result register.
//  The per-byte CRC update plus the status compare in stage 1 sets the
//  cycle time.
//  Synchronous active-low reset loads the register defaults and clears the
//  frame state. When out_ch stalls, the result register holds, stage 1 holds,
//  and in_ch deasserts ready once stage 1 is occupied.
//
`default_nettype none

module crc_frame_decoder_checker_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    cfdc_in_if.sink                         in_ch,
    cfdc_out_if.source                      out_ch,
    input  wire logic                       i_cfg_we,
    input  wire logic [cfdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cfdc_pkg::BYTE_W-1:0]    i_cfg_data
);
    import cfdc_pkg::*;

    localparam int EXT_W = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [EXT_W-1:0]   HDR_EXT   = EXT_W'(HDR_BYTES);
    // Last position of a well-formed frame is header + length + 2 - 1
    localparam logic [EXT_W-1:0]   LAST_OFS  = EXT_W'(HDR_BYTES + CRC_BYTES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] r_sync_first, r_sync_second, r_version, r_max_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= RST_SYNC_FIRST;
            r_sync_second <= RST_SYNC_SECOND;
            r_version     <= RST_VERSION;
            r_max_payload <= RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                CFG_VERSION:     r_version     <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;
    logic              r_out_valid;
    logic              s1_go;

    // Advance stage 1 whenever the result register is free or being drained
    assign s1_go      = r_s1_valid && (!r_out_valid || out_ch.ready);
    assign in_ch.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_s1_valid <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_s1_byte <= in_ch.rx_byte;
            r_s1_last <= in_ch.end_of_frame;
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] r_byte_count;
    logic [CRC_W-1:0]   r_crc;
    logic               r_sync_err, r_ver_err;
    logic [BYTE_W-1:0]  r_hdr_src, r_hdr_dst, r_hdr_type, r_hdr_flags, r_hdr_len;
    logic [SEQ_W-1:0]   r_hdr_seq;
    logic [BYTE_W-1:0]  r_prev_byte;

    logic [COUNT_W-1:0] n_byte_count;
    logic [CRC_W-1:0]   n_crc;
    logic               n_sync_err, n_ver_err;
    logic [BYTE_W-1:0]  n_hdr_src, n_hdr_dst, n_hdr_type, n_hdr_flags, n_hdr_len;
    logic [SEQ_W-1:0]   n_hdr_seq;
    logic [CRC_W-1:0]   trail;
    logic               in_crc_span;
    logic               res_valid;
    t_status            res_status;

    always_comb begin
        n_sync_err  = r_sync_err;
        n_ver_err   = r_ver_err;
        n_hdr_src   = r_hdr_src;
        n_hdr_dst   = r_hdr_dst;
        n_hdr_type  = r_hdr_type;
        n_hdr_flags = r_hdr_flags;
        n_hdr_seq   = r_hdr_seq;
        n_hdr_len   = r_hdr_len;

        // Compare or capture the header byte at its position
        case (r_byte_count)
            POS_SYNC0:   if (r_s1_byte != r_sync_first)  n_sync_err = 1'b1;
            POS_SYNC1:   if (r_s1_byte != r_sync_second) n_sync_err = 1'b1;
            POS_VERSION: if (r_s1_byte != r_version)     n_ver_err  = 1'b1;
            POS_SOURCE:  n_hdr_src   = r_s1_byte;
            POS_DEST:    n_hdr_dst   = r_s1_byte;
            POS_TYPE:    n_hdr_type  = r_s1_byte;
            POS_FLAGS:   n_hdr_flags = r_s1_byte;
            POS_SEQ_HI:  n_hdr_seq   = {r_s1_byte, r_hdr_seq[BYTE_W-1:0]};
            POS_SEQ_LO:  n_hdr_seq   = {r_hdr_seq[SEQ_W-1:BYTE_W], r_s1_byte};
            POS_LENGTH:  n_hdr_len   = r_s1_byte;
            default: ;
        endcase

        // Header and declared payload feed the CRC; trailer bytes do not
        in_crc_span = {1'b0, r_byte_count} < (HDR_EXT + {2'b00, n_hdr_len});
        n_crc       = in_crc_span ? crc16_byte(r_crc, r_s1_byte) : r_crc;
        trail       = {r_prev_byte, r_s1_byte};

        n_byte_count = (r_byte_count != COUNT_MAX) ? r_byte_count + 1'b1 : r_byte_count;

        // Status checks, earliest failing check wins
        if ({1'b0, r_byte_count} < LAST_OFS)
            res_status = ST_TOO_SHORT;
        else if (n_sync_err)
            res_status = ST_BAD_SYNC;
        else if (n_ver_err)
            res_status = ST_BAD_VERSION;
        else if (n_hdr_len > r_max_payload)
            res_status = ST_TOO_LARGE;
        else if ({1'b0, r_byte_count} != (LAST_OFS + {2'b00, n_hdr_len}))
            res_status = ST_LEN_MISMATCH;
        else if (n_crc != trail)
            res_status = ST_CRC_MISMATCH;
        else
            res_status = ST_OK;

        // Non-final bytes give a result only inside the payload span
        res_valid = r_s1_last || (in_crc_span && ({1'b0, r_byte_count} >= HDR_EXT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_go && r_s1_last)) begin
            r_byte_count <= '0;
            r_crc        <= CRC_INIT;
            r_sync_err   <= 1'b0;
            r_ver_err    <= 1'b0;
            r_hdr_src    <= '0;
            r_hdr_dst    <= '0;
            r_hdr_type   <= '0;
            r_hdr_flags  <= '0;
            r_hdr_seq    <= '0;
            r_hdr_len    <= '0;
            r_prev_byte  <= '0;
        end else if (s1_go) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_sync_err   <= n_sync_err;
            r_ver_err    <= n_ver_err;
            r_hdr_src    <= n_hdr_src;
            r_hdr_dst    <= n_hdr_dst;
            r_hdr_type   <= n_hdr_type;
            r_hdr_flags  <= n_hdr_flags;
            r_hdr_seq    <= n_hdr_seq;
            r_hdr_len    <= n_hdr_len;
            r_prev_byte  <= r_s1_byte;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result register
    // ------------------------------------------------------------------
    logic              r_kind;
    logic [BYTE_W-1:0] r_pay_byte, r_pay_idx;
    t_status           r_status;
    logic [BYTE_W-1:0] r_src, r_dst, r_type, r_flags, r_count;
    logic [SEQ_W-1:0]  r_seq;
    logic              hdr_out;

    // Header fields go out only with an ok status
    assign hdr_out = r_s1_last && (res_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= res_valid;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && res_valid) begin
            r_kind     <= r_s1_last ? KIND_STATUS : KIND_PAYLOAD;
            r_pay_byte <= r_s1_last ? '0 : r_s1_byte;
            r_pay_idx  <= r_s1_last ? '0 : BYTE_W'(r_byte_count - COUNT_W'(HDR_BYTES));
            r_status   <= r_s1_last ? res_status : ST_OK;
            r_src      <= hdr_out ? n_hdr_src   : '0;
            r_dst      <= hdr_out ? n_hdr_dst   : '0;
            r_type     <= hdr_out ? n_hdr_type  : '0;
            r_flags    <= hdr_out ? n_hdr_flags : '0;
            r_seq      <= hdr_out ? n_hdr_seq   : '0;
            r_count    <= hdr_out ? n_hdr_len   : '0;
        end
    end

    assign out_ch.valid           = r_out_valid;
    assign out_ch.item_kind       = r_kind;
    assign out_ch.payload_byte    = r_pay_byte;
    assign out_ch.payload_index   = r_pay_idx;
    assign out_ch.status          = r_status;
    assign out_ch.source_node     = r_src;
    assign out_ch.dest_node       = r_dst;
    assign out_ch.message_type    = r_type;
    assign out_ch.flag_bits       = r_flags;
    assign out_ch.sequence_number = r_seq;
    assign out_ch.payload_count   = r_count;

endmodule

`default_nettype wire
